### design/cdll_pkg.sv
// ----------------------------------------------------------------------------
// cdll_pkg: shared types and constants of the cursor linked list
// Sizes of the node pool and links, operation codes, sequencer states,
// and the structs that pass between the sequencer and the top level.
// ----------------------------------------------------------------------------
package cdll_pkg;

    // Pool and word sizes.
    localparam int POOL_DEPTH = 1024;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    // A link also holds the value POOL_DEPTH, which means no node.
    localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_DEPTH);

    // Input and output field widths.
    localparam int OP_W      = 2;
    localparam int RES_BITS  = 3 * DATA_W + 3;
    localparam int OUT_W     = ((RES_BITS + 7) / 8) * 8;
    localparam int IN_W      = ((DATA_W + 7) / 8) * 8;

    // Operation codes carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_INS_BEFORE = 2'd0,
        OP_INS_AFTER  = 2'd1,
        OP_MOVE_BACK  = 2'd2,
        OP_MOVE_FWD   = 2'd3
    } t_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_NODE,
        ST_INS_LINK,
        ST_MV_LINK,
        ST_MV_VALUE,
        ST_MV_CAPTURE,
        ST_DONE
    } t_state;

    // Memory requests for the value, previous-link and next-link stores.
    typedef struct packed {
        logic              val_we;
        logic [IDX_W-1:0]  val_waddr;
        logic [DATA_W-1:0] val_wdata;
        logic [IDX_W-1:0]  val_raddr;
        logic              prev_we;
        logic [IDX_W-1:0]  prev_waddr;
        logic [LINK_W-1:0] prev_wdata;
        logic [IDX_W-1:0]  prev_raddr;
        logic              next_we;
        logic [IDX_W-1:0]  next_waddr;
        logic [LINK_W-1:0] next_wdata;
        logic [IDX_W-1:0]  next_raddr;
    } t_mem_req;

    // One result item.
    typedef struct packed {
        logic              pool_full;
        logic [DATA_W-1:0] next_value;
        logic              next_valid;
        logic [DATA_W-1:0] cur_value;
        logic [DATA_W-1:0] prev_value;
        logic              prev_valid;
    } t_result;

    // True when a link names a node.
    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < NIL_LINK;
    endfunction

endpackage

### design/cdll_ram.sv
// ----------------------------------------------------------------------------
// cdll_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module cdll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/cdll_seq.sv
// ----------------------------------------------------------------------------
// cdll_seq: operation sequencer of the cursor linked list
// Keeps the cursor, its two links and the three node words around it in
// registers, and reads and writes the node stores one step per cycle.
// ----------------------------------------------------------------------------
module cdll_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Operation input.
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cdll_pkg::OP_W-1:0]     i_op,
    input  logic [cdll_pkg::DATA_W-1:0]   i_value,
    // Value of node 0.
    input  logic [cdll_pkg::DATA_W-1:0]   i_init_value,
    // Node store access.
    output cdll_pkg::t_mem_req            o_req,
    input  logic [cdll_pkg::DATA_W-1:0]   i_val_rdata,
    input  logic [cdll_pkg::LINK_W-1:0]   i_prev_rdata,
    input  logic [cdll_pkg::LINK_W-1:0]   i_next_rdata,
    // Result toward the output register.
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output cdll_pkg::t_result             o_res
);

    cdll_pkg::t_state                    r_state, n_state;
    cdll_pkg::t_op                       r_op, n_op;
    logic [cdll_pkg::DATA_W-1:0]         r_val, n_val;
    logic [cdll_pkg::IDX_W-1:0]          r_cur, n_cur;
    logic [cdll_pkg::LINK_W-1:0]         r_cp, n_cp;
    logic [cdll_pkg::LINK_W-1:0]         r_cn, n_cn;
    logic [cdll_pkg::DATA_W-1:0]         r_pv, n_pv;
    logic [cdll_pkg::DATA_W-1:0]         r_cv, n_cv;
    logic [cdll_pkg::DATA_W-1:0]         r_nv, n_nv;
    logic [cdll_pkg::LINK_W-1:0]         r_used, n_used;
    logic                                r_full, n_full;
    logic                                r_zp_wr, n_zp_wr;
    logic                                r_zn_wr, n_zn_wr;

    logic [cdll_pkg::IDX_W-1:0]          new_idx;
    logic [cdll_pkg::LINK_W-1:0]         new_link;
    logic [cdll_pkg::LINK_W-1:0]         cur_link;
    logic [cdll_pkg::LINK_W-1:0]         far_link;
    cdll_pkg::t_mem_req                  req;

    // Index of the node that an insert takes, and the cursor as a link.
    assign new_idx  = r_used[cdll_pkg::IDX_W-1:0];
    assign new_link = cdll_pkg::LINK_W'(new_idx);
    assign cur_link = cdll_pkg::LINK_W'(r_cur);

    // Link read back for the new cursor. Node 0 links read as none until written.
    always_comb begin
        if (r_op == cdll_pkg::OP_MOVE_BACK) begin
            far_link = (r_cur == '0 && !r_zp_wr) ? cdll_pkg::NIL_LINK : i_prev_rdata;
        end else begin
            far_link = (r_cur == '0 && !r_zn_wr) ? cdll_pkg::NIL_LINK : i_next_rdata;
        end
    end

    // Next state, memory requests and register updates.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_val   = r_val;
        n_cur   = r_cur;
        n_cp    = r_cp;
        n_cn    = r_cn;
        n_pv    = r_pv;
        n_cv    = r_cv;
        n_nv    = r_nv;
        n_used  = r_used;
        n_full  = r_full;
        req     = '0;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            cdll_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op   = cdll_pkg::t_op'(i_op);
                    n_val  = i_value;
                    n_full = 1'b0;
                    unique case (cdll_pkg::t_op'(i_op))
                        cdll_pkg::OP_INS_BEFORE, cdll_pkg::OP_INS_AFTER: begin
                            if (r_used == cdll_pkg::NIL_LINK) begin
                                n_full  = 1'b1;
                                n_state = cdll_pkg::ST_DONE;
                            end else begin
                                n_state = cdll_pkg::ST_INS_NODE;
                            end
                        end
                        cdll_pkg::OP_MOVE_BACK: begin
                            n_state = cdll_pkg::link_ok(r_cp) ? cdll_pkg::ST_MV_LINK
                                                              : cdll_pkg::ST_DONE;
                        end
                        default: begin
                            n_state = cdll_pkg::link_ok(r_cn) ? cdll_pkg::ST_MV_LINK
                                                              : cdll_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // Write the new node: its word and both of its links.
            cdll_pkg::ST_INS_NODE: begin
                req.val_we     = 1'b1;
                req.val_waddr  = new_idx;
                req.val_wdata  = r_val;
                req.prev_we    = 1'b1;
                req.prev_waddr = new_idx;
                req.next_we    = 1'b1;
                req.next_waddr = new_idx;
                if (r_op == cdll_pkg::OP_INS_BEFORE) begin
                    req.prev_wdata = r_cp;
                    req.next_wdata = cur_link;
                end else begin
                    req.prev_wdata = cur_link;
                    req.next_wdata = r_cn;
                end
                n_state = cdll_pkg::ST_INS_LINK;
            end

            // Point the cursor and its old neighbor at the new node.
            cdll_pkg::ST_INS_LINK: begin
                if (r_op == cdll_pkg::OP_INS_BEFORE) begin
                    req.prev_we    = 1'b1;
                    req.prev_waddr = r_cur;
                    req.prev_wdata = new_link;
                    req.next_we    = cdll_pkg::link_ok(r_cp);
                    req.next_waddr = r_cp[cdll_pkg::IDX_W-1:0];
                    req.next_wdata = new_link;
                    n_cp = new_link;
                    n_pv = r_val;
                end else begin
                    req.next_we    = 1'b1;
                    req.next_waddr = r_cur;
                    req.next_wdata = new_link;
                    req.prev_we    = cdll_pkg::link_ok(r_cn);
                    req.prev_waddr = r_cn[cdll_pkg::IDX_W-1:0];
                    req.prev_wdata = new_link;
                    n_cn = new_link;
                    n_nv = r_val;
                end
                n_used  = r_used + 1'b1;
                n_state = cdll_pkg::ST_DONE;
            end

            // Shift the window by one node and read the far link of the new cursor.
            cdll_pkg::ST_MV_LINK: begin
                if (r_op == cdll_pkg::OP_MOVE_BACK) begin
                    req.prev_raddr = r_cp[cdll_pkg::IDX_W-1:0];
                    n_cur = r_cp[cdll_pkg::IDX_W-1:0];
                    n_cn  = cur_link;
                    n_nv  = r_cv;
                    n_cv  = r_pv;
                end else begin
                    req.next_raddr = r_cn[cdll_pkg::IDX_W-1:0];
                    n_cur = r_cn[cdll_pkg::IDX_W-1:0];
                    n_cp  = cur_link;
                    n_pv  = r_cv;
                    n_cv  = r_nv;
                end
                n_state = cdll_pkg::ST_MV_VALUE;
            end

            // Take the far link and read the word of the node it names.
            cdll_pkg::ST_MV_VALUE: begin
                req.val_raddr = far_link[cdll_pkg::IDX_W-1:0];
                if (r_op == cdll_pkg::OP_MOVE_BACK) begin
                    n_cp = far_link;
                end else begin
                    n_cn = far_link;
                end
                n_state = cdll_pkg::ST_MV_CAPTURE;
            end

            // Keep the far word.
            cdll_pkg::ST_MV_CAPTURE: begin
                if (r_op == cdll_pkg::OP_MOVE_BACK) begin
                    n_pv = i_val_rdata;
                end else begin
                    n_nv = i_val_rdata;
                end
                n_state = cdll_pkg::ST_DONE;
            end

            // Hand the result over once the output register can take it.
            cdll_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = cdll_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = cdll_pkg::ST_IDLE;
            end
        endcase
    end

    // Node 0 links become readable from the stores once they are written.
    assign n_zp_wr = r_zp_wr | (req.prev_we && req.prev_waddr == '0);
    assign n_zn_wr = r_zn_wr | (req.next_we && req.next_waddr == '0);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdll_pkg::ST_IDLE;
            r_cur   <= '0;
            r_cp    <= cdll_pkg::NIL_LINK;
            r_cn    <= cdll_pkg::NIL_LINK;
            r_used  <= cdll_pkg::LINK_W'(1);
            r_full  <= 1'b0;
            r_zp_wr <= 1'b0;
            r_zn_wr <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_cp    <= n_cp;
            r_cn    <= n_cn;
            r_used  <= n_used;
            r_full  <= n_full;
            r_zp_wr <= n_zp_wr;
            r_zn_wr <= n_zn_wr;
        end
    end

    // Operation and cached node words.
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_val <= n_val;
        r_pv  <= n_pv;
        r_cv  <= n_cv;
        r_nv  <= n_nv;
    end

    // Result: node 0 always shows the live init value.
    always_comb begin
        o_res.prev_valid = cdll_pkg::link_ok(r_cp);
        o_res.prev_value = !cdll_pkg::link_ok(r_cp) ? '0 :
                           (r_cp == '0) ? i_init_value : r_pv;
        o_res.cur_value  = (r_cur == '0) ? i_init_value : r_cv;
        o_res.next_valid = cdll_pkg::link_ok(r_cn);
        o_res.next_value = !cdll_pkg::link_ok(r_cn) ? '0 :
                           (r_cn == '0) ? i_init_value : r_nv;
        o_res.pool_full  = r_full;
    end

    assign o_req = req;

endmodule

### design/cursor_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list: doubly linked list with a cursor
// Node pool in three RAMs, a sequencer, and a registered result output.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transfer: tuser is the operation
//   (insert before, insert after, move back, move forward) and tdata is the
//   word for a new node. m_axis returns one result per operation with the
//   nodes before, at and after the cursor and the pool-full flag.
//   The configuration channel writes the word of node 0; write it only while
//   no operation is in flight.
//   From the input transfer to the result in the output register, an insert
//   steps through node write, link write and hand-over, a move through link
//   read, word read, capture and hand-over, and a dropped insert or a move at
//   a list end goes straight to hand-over. The next operation is taken in the
//   cycle after the hand-over. The dependent RAM accesses set these steps; one
//   operation is in flight at a time.
//   The output register holds a result while m_axis_tready is low; the next
//   operation is taken meanwhile and waits in its last step until the
//   register frees.
//   After reset the list holds node 0 only, the cursor is on it, its word is
//   zero, and no RAM clearing is needed.
// ----------------------------------------------------------------------------
module cursor_doubly_linked_list (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Operation stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cdll_pkg::IN_W-1:0]     s_axis_tdata,  // value
    input  logic [cdll_pkg::OP_W-1:0]     s_axis_tuser,  // op
    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // prev_valid, prev_value, cur_value, next_valid, next_value, pool_full, zero fill
    output logic [cdll_pkg::OUT_W-1:0]    m_axis_tdata,
    // Configuration write of init_value.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cdll_pkg::DATA_W-1:0]   i_cfg_data
);

    logic [cdll_pkg::DATA_W-1:0]  r_init_value;
    logic                         r_m_valid;
    logic [cdll_pkg::OUT_W-1:0]   r_m_data;

    cdll_pkg::t_mem_req           req;
    cdll_pkg::t_result            res;
    logic                         res_valid;
    logic                         res_ready;
    logic [cdll_pkg::DATA_W-1:0]  val_rdata;
    logic [cdll_pkg::LINK_W-1:0]  prev_rdata;
    logic [cdll_pkg::LINK_W-1:0]  next_rdata;

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_value <= '0;
        end else if (i_cfg_valid) begin
            r_init_value <= i_cfg_data;
        end
    end

    // Sequencer.
    cdll_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_value      (s_axis_tdata[cdll_pkg::DATA_W-1:0]),
        .i_init_value (r_init_value),
        .o_req        (req),
        .i_val_rdata  (val_rdata),
        .i_prev_rdata (prev_rdata),
        .i_next_rdata (next_rdata),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // Node words.
    cdll_ram #(
        .WIDTH (cdll_pkg::DATA_W),
        .DEPTH (cdll_pkg::POOL_DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (req.val_we),
        .i_waddr (req.val_waddr),
        .i_wdata (req.val_wdata),
        .i_raddr (req.val_raddr),
        .o_rdata (val_rdata)
    );

    // Previous-node links.
    cdll_ram #(
        .WIDTH (cdll_pkg::LINK_W),
        .DEPTH (cdll_pkg::POOL_DEPTH)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (req.prev_we),
        .i_waddr (req.prev_waddr),
        .i_wdata (req.prev_wdata),
        .i_raddr (req.prev_raddr),
        .o_rdata (prev_rdata)
    );

    // Next-node links.
    cdll_ram #(
        .WIDTH (cdll_pkg::LINK_W),
        .DEPTH (cdll_pkg::POOL_DEPTH)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (req.next_we),
        .i_waddr (req.next_waddr),
        .i_wdata (req.next_wdata),
        .i_raddr (req.next_raddr),
        .o_rdata (next_rdata)
    );

    // Output register: loads when empty or when its result transfers now.
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_data <= cdll_pkg::OUT_W'(res);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Stores are only written while the sequencer is busy, never on an input transfer.
    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !(req.val_we || req.prev_we || req.next_we))
        else $error("node store written in the cycle an operation is accepted");

    // One operation in flight: the sequencer is busy right after a transfer.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second operation accepted while one is in flight");

    // A new node word is written together with both of its links.
    a_node_write_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.val_we |-> (req.prev_we && req.next_we &&
                        req.prev_waddr == req.val_waddr &&
                        req.next_waddr == req.val_waddr))
        else $error("node word written without its links");

    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !m_axis_tready) |=> $stable(r_m_data))
        else $error("pending result overwritten");

endmodule
